### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### hw/rtl/muet_pkg.sv
// Shared constants and reduction tree sizing functions for the unique edge table.
package muet_pkg;

    localparam int DEF_MAX_EDGES = 1024;
    localparam int DEF_NODE_BITS = 16;
    localparam int TREE_FAN      = 32;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // number of words at level l of the OR tree over n leaves
    function automatic int tree_width(int n, int l);
        int w;
        w = n;
        for (int k = 0; k < l; k++)
        begin
            w = (w + TREE_FAN - 1) / TREE_FAN;
        end
        return w;
    endfunction

    function automatic int tree_levels(int n);
        int l;
        l = 0;
        while (tree_width(n, l) > 1)
        begin
            l++;
        end
        return l;
    endfunction

    // word offset of level l when all levels are laid out back to back
    function automatic int tree_offset(int n, int l);
        int s;
        s = 0;
        for (int k = 0; k < l; k++)
        begin
            s += tree_width(n, k);
        end
        return s;
    endfunction

endpackage

### hw/rtl/muet_cell.sv
// One sorted table cell: holds a key, compares it with the probe and shifts on insert.
module muet_cell #(
    parameter int KW  = 32,
    parameter int IW  = 10,
    parameter int CW  = 11,
    parameter int IDX = 0
) (
    input  logic          clk,
    input  logic [KW-1:0] probe,
    input  logic [IW-1:0] rd_idx,
    input  logic [CW-1:0] count,
    input  logic          shift,
    input  logic [KW-1:0] key_in,
    input  logic          lt_in,
    output logic [KW-1:0] key_out,
    output logic          lt_out,
    output logic [KW:0]   leaf
);

    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic          occupied;
    logic          lt;
    logic          eq;
    logic          sel;

    assign occupied = count > CW'(IDX);
    assign lt       = occupied && (key_reg < probe);
    assign eq       = occupied && (key_reg == probe);
    assign sel      = rd_idx == IW'(IDX);

    // insert point takes the probe, cells above it take the left neighbour
    always_comb
    begin
        key_next = key_reg;
        if (shift && !lt)
        begin
            key_next = lt_in ? probe : key_in;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_out = key_reg;
    assign lt_out  = lt;
    assign leaf    = {eq, (sel ? key_reg : {KW{1'b0}})};

endmodule

### hw/rtl/muet_or_tree.sv
// Registered OR reduction tree over the cell leaves, fan-in of TREE_FAN per level.
module muet_or_tree #(
    parameter int N = 1024,
    parameter int W = 33
) (
    input  logic         clk,
    input  logic [N*W-1:0] leaves,
    output logic [W-1:0] root
);

    localparam int LEVELS = muet_pkg::tree_levels(N);
    localparam int ALLW   = muet_pkg::tree_offset(N, LEVELS + 1);

    wire [ALLW*W-1:0] lvl_q;

    assign lvl_q[N*W-1:0] = leaves;

    for (genvar l = 1; l <= LEVELS; l++)
    begin : g_lvl
        localparam int PW   = muet_pkg::tree_width(N, l - 1);
        localparam int NW   = muet_pkg::tree_width(N, l);
        localparam int POFF = muet_pkg::tree_offset(N, l - 1);
        localparam int OFF  = muet_pkg::tree_offset(N, l);

        for (genvar g = 0; g < NW; g++)
        begin : g_grp
            localparam int LO = g * muet_pkg::TREE_FAN;
            localparam int HI = (LO + muet_pkg::TREE_FAN < PW) ?
                                (LO + muet_pkg::TREE_FAN) : PW;

            logic [W-1:0] acc;
            logic [W-1:0] grp_reg;

            always_comb
            begin
                acc = '0;
                for (int j = LO; j < HI; j++)
                begin
                    acc = acc | lvl_q[(POFF + j)*W +: W];
                end
            end

            always_ff @(posedge clk)
            begin
                grp_reg <= acc;
            end

            assign lvl_q[(OFF + g)*W +: W] = grp_reg;
        end
    end

    assign root = lvl_q[(ALLW - 1)*W +: W];

endmodule

### hw/rtl/mesh_unique_edge_table_core.sv
// Top level of the unique edge table: command FSM, cell row, OR tree and result register.
//
// channel  payload                                            transaction when
// in       cmd node_a node_b node_c read_index                in_valid & in_ready
// out      edge_count edge_low edge_high read_valid overflow  out_valid & out_ready
//
// Clear and unused command go straight to S_DONE. Read: S_WAIT, then S_DONE. Triangle:
// per edge S_EDGE, S_WAIT and S_APPLY (S_EDGE only for an edge with equal ends), then
// S_DONE. The registered OR tree over the cells is ceil(log32(MAX_EDGES)) levels deep.
// Reset zeroes the count and overflow flag; table contents stay undefined, no sweep.
// One transaction is worked on at a time; in_ready is high only when idle. A result
// waiting in the output register does not block intake; the next one waits behind it.
`include "assert_macros.svh"

module mesh_unique_edge_table_core #(
    parameter int MAX_EDGES = muet_pkg::DEF_MAX_EDGES,
    parameter int NODE_BITS = muet_pkg::DEF_NODE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [NODE_BITS-1:0]         node_a,
    input  logic [NODE_BITS-1:0]         node_b,
    input  logic [NODE_BITS-1:0]         node_c,
    input  logic [$clog2(MAX_EDGES)-1:0] read_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [$clog2(MAX_EDGES+1)-1:0] edge_count,
    output logic [NODE_BITS-1:0]         edge_low,
    output logic [NODE_BITS-1:0]         edge_high,
    output logic                         read_valid,
    output logic                         overflow
);

    localparam int KW     = 2 * NODE_BITS;
    localparam int LW     = KW + 1;
    localparam int IW     = $clog2(MAX_EDGES);
    localparam int CW     = $clog2(MAX_EDGES + 1);
    localparam int LEVELS = muet_pkg::tree_levels(MAX_EDGES);
    localparam int WCW    = $clog2(LEVELS + 1);

    localparam logic [CW-1:0]  MAX_CNT  = CW'(MAX_EDGES);
    localparam logic [WCW-1:0] WAIT_END = WCW'(LEVELS - 1);

    localparam logic [1:0] CMD_CLEAR  = muet_pkg::CMD_CLEAR;
    localparam logic [1:0] CMD_INSERT = muet_pkg::CMD_INSERT;
    localparam logic [1:0] CMD_READ   = muet_pkg::CMD_READ;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_WAIT,
        S_APPLY,
        S_DONE
    } state_t;

    state_t                 state_reg,    state_next;
    logic [1:0]             cmd_reg,      cmd_next;
    logic [NODE_BITS-1:0]   a_reg,        a_next;
    logic [NODE_BITS-1:0]   b_reg,        b_next;
    logic [NODE_BITS-1:0]   c_reg,        c_next;
    logic [IW-1:0]          rd_idx_reg,   rd_idx_next;
    logic [1:0]             edge_sel_reg, edge_sel_next;
    logic [KW-1:0]          probe_reg,    probe_next;
    logic [WCW-1:0]         wait_reg,     wait_next;
    logic [CW-1:0]          count_reg,    count_next;
    logic                   lost_reg,     lost_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CW-1:0]          out_count_reg, out_count_next;
    logic [NODE_BITS-1:0]   out_lo_reg,   out_lo_next;
    logic [NODE_BITS-1:0]   out_hi_reg,   out_hi_next;
    logic                   out_rv_reg,   out_rv_next;
    logic                   out_ovf_reg,  out_ovf_next;

    logic                   shift_en;
    logic [NODE_BITS-1:0]   cand_p;
    logic [NODE_BITS-1:0]   cand_q;
    logic [KW-1:0]          cell_key [MAX_EDGES];
    logic                   cell_lt  [MAX_EDGES];
    logic [MAX_EDGES*LW-1:0] leaves;
    logic [LW-1:0]          root;
    logic                   dup;
    logic                   hit;

    // cell row
    for (genvar i = 0; i < MAX_EDGES; i++)
    begin : g_cell
        logic [KW-1:0] key_prev;
        logic          lt_prev;

        if (i == 0)
        begin : g_first
            assign key_prev = '0;
            assign lt_prev  = 1'b1;
        end
        else
        begin : g_rest
            assign key_prev = cell_key[i-1];
            assign lt_prev  = cell_lt[i-1];
        end

        muet_cell #(
            .KW  (KW),
            .IW  (IW),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk     (clk),
            .probe   (probe_reg),
            .rd_idx  (rd_idx_reg),
            .count   (count_reg),
            .shift   (shift_en),
            .key_in  (key_prev),
            .lt_in   (lt_prev),
            .key_out (cell_key[i]),
            .lt_out  (cell_lt[i]),
            .leaf    (leaves[i*LW +: LW])
        );
    end

    muet_or_tree #(
        .N (MAX_EDGES),
        .W (LW)
    ) u_tree (
        .clk    (clk),
        .leaves (leaves),
        .root   (root)
    );

    assign dup = root[KW];
    assign hit = CW'(rd_idx_reg) < count_reg;

    always_comb
    begin
        case (edge_sel_reg)
            EDGE_AB:
            begin
                cand_p = a_reg;
                cand_q = b_reg;
            end
            EDGE_BC:
            begin
                cand_p = b_reg;
                cand_q = c_reg;
            end
            default:
            begin
                cand_p = c_reg;
                cand_q = a_reg;
            end
        endcase
    end

    assign shift_en = (state_reg == S_APPLY) && !dup && (count_reg != MAX_CNT);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        rd_idx_next    = rd_idx_reg;
        edge_sel_next  = edge_sel_reg;
        probe_next     = probe_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        lost_next      = lost_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_count_next = out_count_reg;
        out_lo_next    = out_lo_reg;
        out_hi_next    = out_hi_reg;
        out_rv_next    = out_rv_reg;
        out_ovf_next   = out_ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = cmd;
                    a_next        = node_a;
                    b_next        = node_b;
                    c_next        = node_c;
                    rd_idx_next   = read_index;
                    edge_sel_next = EDGE_AB;
                    wait_next     = '0;
                    unique case (cmd)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            lost_next  = 1'b0;
                            state_next = S_DONE;
                        end
                        CMD_INSERT: state_next = S_EDGE;
                        CMD_READ:   state_next = S_WAIT;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_EDGE:
            begin
                if (cand_p == cand_q)
                begin
                    if (edge_sel_reg == EDGE_CA)
                        state_next = S_DONE;
                    else
                        edge_sel_next = edge_sel_reg + 2'd1;
                end
                else
                begin
                    probe_next = (cand_p < cand_q) ? {cand_p, cand_q} : {cand_q, cand_p};
                    wait_next  = '0;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (wait_reg == WAIT_END)
                    state_next = (cmd_reg == CMD_READ) ? S_DONE : S_APPLY;
                else
                    wait_next = wait_reg + WCW'(1);
            end
            S_APPLY:
            begin
                if (!dup)
                begin
                    if (count_reg == MAX_CNT)
                        lost_next = 1'b1;
                    else
                        count_next = count_reg + CW'(1);
                end
                if (edge_sel_reg == EDGE_CA)
                    state_next = S_DONE;
                else
                begin
                    edge_sel_next = edge_sel_reg + 2'd1;
                    state_next    = S_EDGE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = count_reg;
                    out_ovf_next   = lost_reg;
                    if ((cmd_reg == CMD_READ) && hit)
                    begin
                        out_lo_next = root[KW-1:NODE_BITS];
                        out_hi_next = root[NODE_BITS-1:0];
                        out_rv_next = 1'b1;
                    end
                    else
                    begin
                        out_lo_next = '0;
                        out_hi_next = '0;
                        out_rv_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            lost_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            edge_sel_reg  <= EDGE_AB;
            wait_reg      <= '0;
            cmd_reg       <= CMD_CLEAR;
            out_count_reg <= '0;
            out_lo_reg    <= '0;
            out_hi_reg    <= '0;
            out_rv_reg    <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lost_reg      <= lost_next;
            out_valid_reg <= out_valid_next;
            edge_sel_reg  <= edge_sel_next;
            wait_reg      <= wait_next;
            cmd_reg       <= cmd_next;
            out_count_reg <= out_count_next;
            out_lo_reg    <= out_lo_next;
            out_hi_reg    <= out_hi_next;
            out_rv_reg    <= out_rv_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        c_reg         <= c_next;
        rd_idx_reg    <= rd_idx_next;
        probe_reg     <= probe_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign edge_count = out_count_reg;
    assign edge_low   = out_lo_reg;
    assign edge_high  = out_hi_reg;
    assign read_valid = out_rv_reg;
    assign overflow   = out_ovf_reg;

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > MAX_CNT)
    `ASSERT_AT(a_shift_counts, clk, rst_n, shift_en |=> count_reg == $past(count_reg) + CW'(1))
    `ASSERT_AT(a_busy_after_take, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    `ASSERT_AT(a_lost_sticky, clk, rst_n, $fell(lost_reg) |-> $past(in_ready && cmd == CMD_CLEAR))
    `ASSERT_AT(a_result_from_done, clk, rst_n, $rose(out_valid_reg) |-> $past(state_reg == S_DONE))

endmodule
